// ----- rtl/core/aps_pkg.sv -----
// shared types, constants and series coefficients of the aberration phase sum core
package aps_pkg;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int TERM_W = 72;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_WAVELENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TERMS      = 2'd1;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;

	localparam logic [3:0] STEP_FIRST = 4'd2;
	localparam logic [3:0] STEP_LAST  = 4'd11;

	localparam logic [31:0] RCP_2  = 32'((64'd1 << 32) / 64'd2);
	localparam logic [31:0] RCP_3  = 32'((64'd1 << 33) / 64'd6);
	localparam logic [31:0] RCP_4  = 32'((64'd1 << 35) / 64'd24);
	localparam logic [31:0] RCP_5  = 32'((64'd1 << 37) / 64'd120);
	localparam logic [31:0] RCP_6  = 32'((64'd1 << 40) / 64'd720);
	localparam logic [31:0] RCP_7  = 32'((64'd1 << 43) / 64'd5040);
	localparam logic [31:0] RCP_8  = 32'((64'd1 << 46) / 64'd40320);
	localparam logic [31:0] RCP_9  = 32'((64'd1 << 49) / 64'd362880);
	localparam logic [31:0] RCP_10 = 32'((64'd1 << 52) / 64'd3628800);
	localparam logic [31:0] RCP_11 = 32'((64'd1 << 56) / 64'd39916800);

	typedef enum logic [4:0] {
		ST_IDLE, ST_ALPHA_MUL, ST_ALPHA_WB, ST_FETCH, ST_FETCH_WB,
		ST_POW_MUL, ST_POW_WB, ST_X_MUL, ST_X_WB, ST_PWR_MUL, ST_PWR_WB,
		ST_DIV_MUL, ST_DIV_WB, ST_CHK_MUL, ST_CHK_WB, ST_COS,
		ST_MAG_HI, ST_MAG_LO, ST_MAG_WB, ST_CS_HI, ST_CS_LO, ST_CS_WB,
		ST_ACC, ST_OUT
	} state_t;

	typedef struct packed {
		logic [31:0] rcp;
		logic [5:0]  shift;
		logic [25:0] divisor;
		logic        sub;
	} series_t;

	function automatic series_t series_coef(input logic [3:0] step);
		series_t r;
		unique case (step)
			4'd2:    r = '{RCP_2,  6'd32, 26'd2,        1'b1};
			4'd3:    r = '{RCP_3,  6'd33, 26'd6,        1'b1};
			4'd4:    r = '{RCP_4,  6'd35, 26'd24,       1'b0};
			4'd5:    r = '{RCP_5,  6'd37, 26'd120,      1'b0};
			4'd6:    r = '{RCP_6,  6'd40, 26'd720,      1'b1};
			4'd7:    r = '{RCP_7,  6'd43, 26'd5040,     1'b1};
			4'd8:    r = '{RCP_8,  6'd46, 26'd40320,    1'b0};
			4'd9:    r = '{RCP_9,  6'd49, 26'd362880,   1'b0};
			4'd10:   r = '{RCP_10, 6'd52, 26'd3628800,  1'b1};
			4'd11:   r = '{RCP_11, 6'd56, 26'd39916800, 1'b0};
			default: r = '{32'd0,  6'd32, 26'd1,        1'b0};
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/aberration_phase_sum_core.sv -----
// top level: term table, sequencer and datapath of the aberration phase sum
//
// Input words on s_*: s_tuser selects a load (0) or a pixel (1). A load writes
// one term into the table; s_tready stays high after it.
// A pixel word starts an evaluation; s_tready is low until the result has been
// placed in the output register. The shared 33x33 multiplier forms the
// products of the alpha power loop, the Taylor powers and the reciprocal
// divisions of the cosine, and the split magnitude products. Config writes
// on wr_* are taken at any cycle the enable is high and must happen while
// the core is idle. Results on m_* sit in an output register; while the
// receiver stalls a new pixel may be computed but is held until the register
// frees. Reset clears the config registers, the sequencer and the output
// valid; the table is undefined until loaded and needs no clearing pass.
module aberration_phase_sum_core #(
	parameter int MAX_TERMS  = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// term_slot, radial_order, angular_fold, term_magnitude, term_angle,
	// spatial_freq, azimuth
	input  logic [127:0]                   s_tdata,
	// req_type
	input  logic [0:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// chi_phase
	output logic [63:0]                    m_tdata,
	// alpha_saturated, sum_overflow
	output logic [1:0]                     m_tuser,
	input  logic                           wr_en,
	input  logic [aps_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [31:0]                    wr_data
);

	localparam int AW  = MAX_TERMS > 1 ? $clog2(MAX_TERMS) : 1;
	localparam int CW  = $clog2(MAX_TERMS + 1);
	localparam int AXW = ANGLE_BITS > 16 ? ANGLE_BITS : 16;

	aps_pkg::state_t state_q, state_d;

	logic [31:0] wavelength_q;
	logic [4:0]  terms_q;
	logic [31:0] freq_q;
	logic [15:0] az_q;
	logic [31:0] alpha_q;
	logic        asat_q;
	logic [CW-1:0] cnt_q, k_q;
	logic        neg_q;
	logic [47:0] amag_q;
	logic [3:0]  pcnt_q;
	logic [32:0] p_q;
	logic [1:0]  quad_q;
	logic        refl_q;
	logic [29:0] rf_q;
	logic [30:0] x_q, x2_q, x4_q, x8_q, cur_q, q0_q;
	logic [3:0]  step_q;
	logic signed [32:0] c_q, s_q;
	logic [31:0] csm_q;
	logic [65:0] hp_q;
	logic [47:0] v_q;
	logic signed [48:0] term_q;
	logic signed [63:0] acc_q;
	logic        ovf_q;
	logic        m_tvalid_q;
	logic [63:0] chi_q;
	logic        oasat_q, oovf_q;

	logic [aps_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic [aps_pkg::PROD_W-1:0] prod_q;

	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [aps_pkg::TERM_W-1:0] ram_wdata, rd_q;
	logic [AW+3:0]             slot_x;

	logic s_fire, out_fire;
	logic [CW-1:0] lim;
	aps_pkg::series_t sc;

	logic [3:0]  rd_m, rd_n;
	logic [47:0] rd_mag;
	logic [15:0] rd_ang;
	logic [AXW-1:0] diff_full;
	logic [ANGLE_BITS-1:0] diff, ph;
	logic [ANGLE_BITS+3:0] ph_full;
	logic [31:0] ph32;
	logic [29:0] r_raw;
	logic [30:0] rf31;
	logic [65:0] q0_full;
	logic [30:0] rem, qd;
	logic signed [32:0] cc, ss, cs;
	logic [81:0] mix_sum;
	logic signed [64:0] acc_sum;
	logic [CW:0] k_next;

	assign s_fire   = s_tvalid && s_tready;
	assign out_fire = (state_q == aps_pkg::ST_OUT) && (!m_tvalid_q || m_tready);
	assign lim = (32'(terms_q) > MAX_TERMS) ? CW'(MAX_TERMS) : CW'(terms_q);
	assign sc  = aps_pkg::series_coef(step_q);
	assign k_next = (CW + 1)'(k_q) + (CW + 1)'(1);

	assign slot_x    = (AW + 4)'(s_tdata[3:0]);
	assign ram_waddr = slot_x[AW-1:0];
	assign ram_wdata = {s_tdata[7:4], s_tdata[11:8], s_tdata[59:12], s_tdata[75:60]};
	assign ram_we    = s_fire && (s_tuser[0] == aps_pkg::REQ_LOAD)
		&& (32'(s_tdata[3:0]) < MAX_TERMS);

	aps_ram #(.WIDTH(aps_pkg::TERM_W), .DEPTH(MAX_TERMS)) u_table (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr   (k_q[AW-1:0]),
		.rdata_q (rd_q)
	);

	aps_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign rd_m   = rd_q[71:68];
	assign rd_n   = rd_q[67:64];
	assign rd_mag = rd_q[63:16];
	assign rd_ang = rd_q[15:0];

	// phase fold of n * (azimuth - angle)
	assign diff_full = AXW'(az_q) - AXW'(rd_ang);
	assign diff      = diff_full[ANGLE_BITS-1:0];
	assign ph_full   = (ANGLE_BITS + 4)'(diff) * (ANGLE_BITS + 4)'(rd_n);
	assign ph        = ph_full[ANGLE_BITS-1:0];
	assign ph32      = 32'(ph) << (32 - ANGLE_BITS);
	assign r_raw     = ph32[29:0];
	assign rf31      = 31'h40000000 - {1'b0, r_raw};

	assign q0_full = prod_q >> sc.shift;
	assign rem     = cur_q - prod_q[30:0];
	assign qd      = q0_q + 31'(rem >= 31'(sc.divisor));

	assign cc = refl_q ? s_q : c_q;
	assign ss = refl_q ? c_q : s_q;
	always_comb begin
		case (quad_q)
			2'd0:    cs = cc;
			2'd1:    cs = -ss;
			2'd2:    cs = -cc;
			default: cs = ss;
		endcase
	end

	assign mix_sum = {hp_q, 16'd0} + 82'(prod_q);
	assign acc_sum = {acc_q[63], acc_q} + {{16{term_q[48]}}, term_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			aps_pkg::ST_IDLE: begin
				if (s_fire && s_tuser[0] == aps_pkg::REQ_PIXEL) state_d = aps_pkg::ST_ALPHA_MUL;
			end
			aps_pkg::ST_ALPHA_MUL: state_d = aps_pkg::ST_ALPHA_WB;
			aps_pkg::ST_ALPHA_WB: begin
				state_d = (lim == '0) ? aps_pkg::ST_OUT : aps_pkg::ST_FETCH;
			end
			aps_pkg::ST_FETCH: state_d = aps_pkg::ST_FETCH_WB;
			aps_pkg::ST_FETCH_WB: begin
				state_d = (rd_m == 4'd0) ? aps_pkg::ST_X_MUL : aps_pkg::ST_POW_MUL;
			end
			aps_pkg::ST_POW_MUL: state_d = aps_pkg::ST_POW_WB;
			aps_pkg::ST_POW_WB: begin
				state_d = (pcnt_q == 4'd1) ? aps_pkg::ST_X_MUL : aps_pkg::ST_POW_MUL;
			end
			aps_pkg::ST_X_MUL:   state_d = aps_pkg::ST_X_WB;
			aps_pkg::ST_X_WB:    state_d = aps_pkg::ST_PWR_MUL;
			aps_pkg::ST_PWR_MUL: state_d = aps_pkg::ST_PWR_WB;
			aps_pkg::ST_PWR_WB:  state_d = aps_pkg::ST_DIV_MUL;
			aps_pkg::ST_DIV_MUL: state_d = aps_pkg::ST_DIV_WB;
			aps_pkg::ST_DIV_WB:  state_d = aps_pkg::ST_CHK_MUL;
			aps_pkg::ST_CHK_MUL: state_d = aps_pkg::ST_CHK_WB;
			aps_pkg::ST_CHK_WB: begin
				state_d = (step_q == aps_pkg::STEP_LAST) ? aps_pkg::ST_COS : aps_pkg::ST_PWR_MUL;
			end
			aps_pkg::ST_COS:    state_d = aps_pkg::ST_MAG_HI;
			aps_pkg::ST_MAG_HI: state_d = aps_pkg::ST_MAG_LO;
			aps_pkg::ST_MAG_LO: state_d = aps_pkg::ST_MAG_WB;
			aps_pkg::ST_MAG_WB: state_d = aps_pkg::ST_CS_HI;
			aps_pkg::ST_CS_HI:  state_d = aps_pkg::ST_CS_LO;
			aps_pkg::ST_CS_LO:  state_d = aps_pkg::ST_CS_WB;
			aps_pkg::ST_CS_WB:  state_d = aps_pkg::ST_ACC;
			aps_pkg::ST_ACC: begin
				state_d = (k_next == (CW + 1)'(cnt_q)) ? aps_pkg::ST_OUT : aps_pkg::ST_FETCH;
			end
			aps_pkg::ST_OUT: begin
				if (out_fire) state_d = aps_pkg::ST_IDLE;
			end
			default: state_d = aps_pkg::ST_IDLE;
		endcase
	end

	// multiplier operand select and handshake outputs
	always_comb begin
		s_tready = (state_q == aps_pkg::ST_IDLE);
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			aps_pkg::ST_ALPHA_MUL: begin
				mul_a = 33'(wavelength_q);
				mul_b = 33'(freq_q);
			end
			aps_pkg::ST_POW_MUL: begin
				mul_a = p_q;
				mul_b = 33'(alpha_q);
			end
			aps_pkg::ST_X_MUL: begin
				mul_a = 33'(rf_q);
				mul_b = 33'(aps_pkg::HALF_PI_Q30);
			end
			aps_pkg::ST_PWR_MUL: begin
				case (step_q)
					4'd2:    begin mul_a = 33'(x_q);   mul_b = 33'(x_q);  end
					4'd3:    begin mul_a = 33'(x2_q);  mul_b = 33'(x_q);  end
					4'd4:    begin mul_a = 33'(x2_q);  mul_b = 33'(x2_q); end
					4'd5:    begin mul_a = 33'(x4_q);  mul_b = 33'(x_q);  end
					4'd6:    begin mul_a = 33'(x4_q);  mul_b = 33'(x2_q); end
					4'd8:    begin mul_a = 33'(x4_q);  mul_b = 33'(x4_q); end
					4'd9:    begin mul_a = 33'(x8_q);  mul_b = 33'(x_q);  end
					4'd10:   begin mul_a = 33'(x8_q);  mul_b = 33'(x2_q); end
					default: begin mul_a = 33'(cur_q); mul_b = 33'(x_q);  end
				endcase
			end
			aps_pkg::ST_DIV_MUL: begin
				mul_a = 33'(cur_q);
				mul_b = 33'(sc.rcp);
			end
			aps_pkg::ST_CHK_MUL: begin
				mul_a = 33'(q0_q);
				mul_b = 33'(sc.divisor);
			end
			aps_pkg::ST_MAG_HI: begin
				mul_a = 33'(amag_q[47:16]);
				mul_b = p_q;
			end
			aps_pkg::ST_MAG_LO: begin
				mul_a = 33'(amag_q[15:0]);
				mul_b = p_q;
			end
			aps_pkg::ST_CS_HI: begin
				mul_a = 33'(v_q[47:16]);
				mul_b = 33'(csm_q);
			end
			aps_pkg::ST_CS_LO: begin
				mul_a = 33'(v_q[15:0]);
				mul_b = 33'(csm_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= aps_pkg::ST_IDLE;
			m_tvalid_q   <= 1'b0;
			wavelength_q <= '0;
			terms_q      <= '0;
		end else begin
			state_q    <= state_d;
			m_tvalid_q <= out_fire || (m_tvalid_q && !m_tready);
			if (wr_en) begin
				unique case (wr_index)
					aps_pkg::REG_WAVELENGTH: wavelength_q <= wr_data;
					aps_pkg::REG_TERMS:      terms_q <= wr_data[4:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			aps_pkg::ST_IDLE: begin
				freq_q <= s_tdata[107:76];
				az_q   <= s_tdata[123:108];
			end
			aps_pkg::ST_ALPHA_WB: begin
				asat_q  <= |prod_q[63:56];
				alpha_q <= (|prod_q[63:56]) ? 32'hFFFFFFFF : prod_q[55:24];
				cnt_q   <= lim;
				k_q     <= '0;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
			end
			aps_pkg::ST_FETCH_WB: begin
				neg_q  <= rd_mag[47];
				amag_q <= rd_mag[47] ? (48'd0 - rd_mag) : rd_mag;
				pcnt_q <= rd_m;
				p_q    <= 33'h100000000;
				quad_q <= ph32[31:30];
				refl_q <= r_raw > 30'h20000000;
				rf_q   <= (r_raw > 30'h20000000) ? rf31[29:0] : r_raw;
			end
			aps_pkg::ST_POW_WB: begin
				p_q    <= {1'b0, prod_q[63:32]};
				pcnt_q <= pcnt_q - 4'd1;
			end
			aps_pkg::ST_X_WB: begin
				x_q    <= prod_q[60:30];
				s_q    <= 33'(prod_q[60:30]);
				c_q    <= aps_pkg::ONE_Q30;
				step_q <= aps_pkg::STEP_FIRST;
			end
			aps_pkg::ST_PWR_WB: begin
				cur_q <= prod_q[60:30];
				if (step_q == 4'd2) x2_q <= prod_q[60:30];
				if (step_q == 4'd4) x4_q <= prod_q[60:30];
				if (step_q == 4'd8) x8_q <= prod_q[60:30];
			end
			aps_pkg::ST_DIV_WB: q0_q <= q0_full[30:0];
			aps_pkg::ST_CHK_WB: begin
				if (step_q[0]) begin
					s_q <= sc.sub ? (s_q - 33'(qd)) : (s_q + 33'(qd));
				end else begin
					c_q <= sc.sub ? (c_q - 33'(qd)) : (c_q + 33'(qd));
				end
				step_q <= step_q + 4'd1;
			end
			aps_pkg::ST_COS: begin
				neg_q <= neg_q ^ cs[32];
				csm_q <= cs[32] ? 32'(-cs) : 32'(cs);
			end
			aps_pkg::ST_MAG_LO: hp_q <= prod_q;
			aps_pkg::ST_MAG_WB: v_q <= mix_sum[79:32];
			aps_pkg::ST_CS_LO:  hp_q <= prod_q;
			aps_pkg::ST_CS_WB: begin
				term_q <= neg_q ? -$signed({1'b0, mix_sum[77:30]})
					: $signed({1'b0, mix_sum[77:30]});
			end
			aps_pkg::ST_ACC: begin
				k_q <= k_next[CW-1:0];
				if (acc_sum[64] != acc_sum[63]) begin
					acc_q <= acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
					ovf_q <= 1'b1;
				end else begin
					acc_q <= acc_sum[63:0];
				end
			end
			aps_pkg::ST_OUT: begin
				if (out_fire) begin
					chi_q   <= acc_q;
					oasat_q <= asat_q;
					oovf_q  <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = chi_q;
	assign m_tuser  = {oovf_q, oasat_q};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=>
		(m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("output word changed while stalled");

	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0] == aps_pkg::REQ_PIXEL) |=> !s_tready)
		else $error("ready after pixel accept");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aps_pkg::ST_FETCH) |-> (k_q < cnt_q))
		else $error("term index past count");

endmodule

// ----- rtl/core/aps_ram.sv -----
// generic single write port ram with registered read
module aps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

// ----- rtl/core/aps_mul.sv -----
// shared unsigned multiplier with registered product
module aps_mul (
	input  logic                       clk,
	input  logic [aps_pkg::MUL_W-1:0]  a,
	input  logic [aps_pkg::MUL_W-1:0]  b,
	output logic [aps_pkg::PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= aps_pkg::PROD_W'(a) * aps_pkg::PROD_W'(b);
	end

endmodule

// ----- tb/tb_aberration_phase_sum_core.sv -----
// self-checking testbench of the aberration phase sum core: term loads, pixel sums, config sweeps
module tb_aberration_phase_sum_core;

	localparam int N_SLOTS = 16;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic [63:0] chi;
		logic        asat;
		logic        ovf;
	} pixel_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         wr_en;
	logic [aps_pkg::CFG_IDX_W-1:0] wr_index;
	logic [31:0]  wr_data;

	logic [31:0]  lambda_q32;
	logic [4:0]   n_terms;
	logic [47:0]  coef_tab [N_SLOTS];
	logic [3:0]   order_tab [N_SLOTS];
	logic [3:0]   fold_tab [N_SLOTS];
	logic [15:0]  angle_tab [N_SLOTS];

	pixel_result_t chi_pending [$];
	int           n_errors;
	longint       n_cycles;
	int           burst_left;
	int           rx_mode;
	int           rx_left;

	aberration_phase_sum_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] mul_down(input logic [63:0] a, input logic [63:0] b,
			input int s);
		logic [127:0] t;
		t = {64'd0, a} * {64'd0, b};
		return 64'(t >> s);
	endfunction

	function automatic longint cos_fx(input logic [31:0] ph);
		logic [1:0] quad;
		longint unsigned r, x, x2, x3, x4, x5, x6, x7, x8, x9, x10, x11;
		longint c, s, t;
		bit refl;
		quad = ph[31:30];
		r = {34'd0, ph[29:0]};
		refl = r > 64'h20000000;
		if (refl) r = 64'h40000000 - r;
		x = (r * 64'(aps_pkg::HALF_PI_Q30)) >> 30;
		x2 = (x * x) >> 30;
		x3 = (x2 * x) >> 30;
		x4 = (x2 * x2) >> 30;
		x5 = (x4 * x) >> 30;
		x6 = (x4 * x2) >> 30;
		x7 = (x6 * x) >> 30;
		x8 = (x4 * x4) >> 30;
		x9 = (x8 * x) >> 30;
		x10 = (x8 * x2) >> 30;
		x11 = (x10 * x) >> 30;
		c = 64'd1073741824 - longint'(x2 / 2) + longint'(x4 / 24) - longint'(x6 / 720)
			+ longint'(x8 / 40320) - longint'(x10 / 3628800);
		s = longint'(x) - longint'(x3 / 6) + longint'(x5 / 120) - longint'(x7 / 5040)
			+ longint'(x9 / 362880) + longint'(x11 / 39916800);
		if (refl) begin
			t = c;
			c = s;
			s = t;
		end
		case (quad)
			2'd0: return c;
			2'd1: return -s;
			2'd2: return -c;
			default: return s;
		endcase
	endfunction

	function automatic pixel_result_t phase_sum(input logic [31:0] q, input logic [15:0] az);
		pixel_result_t res;
		logic [63:0] prod, alpha, p, amag, mt;
		logic [15:0] ph;
		logic signed [65:0] acc, nxt, term;
		longint cs;
		bit neg;
		int count;
		acc = '0;
		res = '0;
		prod = ({32'd0, lambda_q32} * {32'd0, q}) >> 24;
		if (prod > 64'hFFFFFFFF) begin
			alpha = 64'hFFFFFFFF;
			res.asat = 1'b1;
		end else begin
			alpha = prod;
		end
		count = (n_terms > N_SLOTS) ? N_SLOTS : n_terms;
		for (int k = 0; k < count; k++) begin
			neg = coef_tab[k][47];
			amag = neg ? (64'd1 << 48) - {16'd0, coef_tab[k]} : {16'd0, coef_tab[k]};
			p = 64'd1 << 32;
			for (int i = 0; i < order_tab[k]; i++) p = mul_down(p, alpha, 32);
			ph = 16'({12'd0, fold_tab[k]} * (az - angle_tab[k]));
			cs = cos_fx({ph, 16'd0});
			if (cs < 0) begin
				neg = !neg;
				cs = -cs;
			end
			mt = mul_down(mul_down(amag, p, 32), 64'(cs), 30);
			term = neg ? -$signed({2'b00, mt}) : $signed({2'b00, mt});
			nxt = acc + term;
			if (nxt > 66'sh7FFFFFFFFFFFFFFF) begin
				acc = 66'sh7FFFFFFFFFFFFFFF;
				res.ovf = 1'b1;
			end else if (nxt < -66'sh8000000000000000) begin
				acc = -66'sh8000000000000000;
				res.ovf = 1'b1;
			end else begin
				acc = nxt;
			end
		end
		res.chi = acc[63:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, n_cycles);
		n_errors++;
	endtask

	// sends one word at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(input logic req, input logic [3:0] slot, input logic [3:0] m,
			input logic [3:0] n, input logic [47:0] mag, input logic [15:0] ang,
			input logic [31:0] q, input logic [15:0] az);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {4'd0, az, q, ang, mag, n, m, slot};
		do @(posedge clk); while (!s_tready);
		if (req == aps_pkg::REQ_LOAD) begin
			coef_tab[slot] = mag;
			order_tab[slot] = m;
			fold_tab[slot] = n;
			angle_tab[slot] = ang;
		end else begin
			chi_pending = {chi_pending, phase_sum(q, az)};
		end
		@(negedge clk);
	endtask

	task automatic load_term(input logic [3:0] slot, input logic [3:0] m, input logic [3:0] n,
			input logic [47:0] mag, input logic [15:0] ang);
		send_word(aps_pkg::REQ_LOAD, slot, m, n, mag, ang, $urandom, 16'($urandom));
	endtask

	task automatic send_pixel(input logic [31:0] q, input logic [15:0] az);
		send_word(aps_pkg::REQ_PIXEL, 4'($urandom), 4'($urandom), 4'($urandom),
			{$urandom, 16'($urandom)}, 16'($urandom), q, az);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (chi_pending.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(input logic [aps_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		if (idx == aps_pkg::REG_WAVELENGTH) lambda_q32 = val;
		else if (idx == aps_pkg::REG_TERMS) n_terms = val[4:0];
		@(negedge clk);
	endtask

	task automatic setup(input logic [31:0] lam, input logic [31:0] terms);
		drain();
		write_reg(aps_pkg::REG_WAVELENGTH, lam);
		write_reg(aps_pkg::REG_TERMS, terms);
	endtask

	task automatic test_table_load;
		for (int k = 0; k < N_SLOTS; k++)
			load_term(4'(k), 4'(k), 4'(15 - k), (k % 2) ? 48'h800000000000 : 48'h7FFFFFFFFFFF,
				(k % 3 == 0) ? 16'hFFFF : 16'(k * 4099));
	endtask

	task automatic test_zero_terms;
		setup(32'hFFFFFFFF, 32'd0);
		send_pixel(32'hFFFFFFFF, 16'h0000);
		send_pixel(32'h00000000, 16'hFFFF);
	endtask

	task automatic test_alpha_extremes;
		setup(32'hFFFFFFFF, 32'd4);
		send_pixel(32'hFFFFFFFF, 16'h4000);
		send_pixel(32'h01000000, 16'h8000);
		send_pixel(32'h00FFFFFF, 16'hC000);
		setup(32'd0, 32'd3);
		send_pixel(32'hFFFFFFFF, 16'h2000);
		send_pixel(32'h00000001, 16'hFFFF);
	endtask

	task automatic test_full_table;
		setup(32'h80000000, 32'd16);
		send_pixel(32'h01800000, 16'h1234);
		setup(32'h40000000, 32'd31);
		send_pixel(32'h02000000, 16'hFEDC);
		// unknown index must leave both registers alone
		drain();
		write_reg(2'd2, 32'hFFFFFFFF);
		write_reg(2'd3, 32'h00000000);
		send_pixel(32'h00C00000, 16'h0001);
		// upper bits of the count word are dropped
		setup(32'h20000000, 32'hFFFFFFE2);
		send_pixel(32'h03000000, 16'h7FFF);
	endtask

	task automatic test_angle_extremes;
		setup(32'h10000000, 32'd1);
		load_term(4'd0, 4'd0, 4'd1, 48'h000000010000, 16'h0000);
		send_pixel(32'd0, 16'h0000);
		send_pixel(32'd0, 16'hFFFF);
		send_pixel(32'd0, 16'h2000);
		send_pixel(32'd0, 16'h6000);
		load_term(4'd0, 4'd15, 4'd0, 48'hFFFFFFFF0000, 16'hFFFF);
		send_pixel(32'hFFFFFFFF, 16'h8000);
	endtask

	task automatic test_random;
		logic [31:0] lam, q;
		int terms, n_items, sh;
		for (int ph = 0; ph < 22; ph++) begin
			case ($urandom_range(0, 4))
				0: lam = 32'hFFFFFFFF;
				1: lam = 32'd0;
				default: lam = $urandom >> $urandom_range(0, 12);
			endcase
			terms = (ph % 9 == 4) ? $urandom_range(16, 31) : $urandom_range(0, 5);
			setup(lam, terms);
			n_items = $urandom_range(25, 40);
			for (int i = 0; i < n_items; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					load_term(4'($urandom), 4'($urandom), 4'($urandom),
						{$urandom, 16'($urandom)}, 16'($urandom));
				end else begin
					sh = $urandom_range(0, 31);
					q = $urandom >> sh;
					send_pixel(q, 16'($urandom));
				end
			end
		end
	endtask

	// receiver stall pattern: open, random, or long stalls
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 2);
			rx_left <= $urandom_range(50, 400);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(0, 1);
			default: m_tready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (chi_pending.size() == 0) begin
				report_mismatch("unexpected word", m_tdata, 64'd0);
			end else begin
				want = chi_pending.pop_front();
				if (m_tdata !== want.chi) report_mismatch("chi_phase", m_tdata, want.chi);
				if (m_tuser[0] !== want.asat)
					report_mismatch("alpha_saturated", m_tuser[0], want.asat);
				if (m_tuser[1] !== want.ovf)
					report_mismatch("sum_overflow", m_tuser[1], want.ovf);
			end
		end
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout at cycle %0d", n_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		n_errors = 0;
		n_cycles = 0;
		burst_left = 0;
		rx_mode = 0;
		rx_left = 0;
		lambda_q32 = '0;
		n_terms = '0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_table_load();
		test_zero_terms();
		test_alpha_extremes();
		test_full_table();
		test_angle_extremes();
		test_random();
		drain();
		if (n_errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
